### design/egs_pkg.sv
`timescale 1ns / 1ps

package egs_pkg;

  localparam int EGS_NUM_PROCS = 32;

  localparam int FUNC_W   = 2;
  localparam int PID_W    = 5;
  localparam int PSTATE_W = 2;
  localparam int PRIO_W   = 8;
  localparam int CREDIT_W = 9;
  localparam int GOOD_W   = CREDIT_W + 1;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = FUNC_W;
  localparam int OUT_TDATA_W = 16;

  localparam logic [FUNC_W-1:0] FN_RESCHED   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SET_STATE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SET_PRIO  = 2'd2;

  typedef enum logic [PSTATE_W-1:0] {
    PS_FREE    = 2'd0,
    PS_RUNNING = 2'd1,
    PS_READY   = 2'd2,
    PS_WAITING = 2'd3
  } pstate_t;

  typedef struct packed {
    pstate_t               st;
    logic [CREDIT_W-1:0]   credit;
    logic [PRIO_W-1:0]     prio;
    logic [PRIO_W-1:0]     pend;
  } row_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDIT_RD,
    S_EDIT_WR,
    S_CUR_RD,
    S_CUR_WR,
    S_CHECK,
    S_EPOCH,
    S_PICK,
    S_FIN_CUR,
    S_FIN_PICK,
    S_DONE
  } seq_state_t;

  // Contents of a table row that has not been written since reset.
  function automatic row_t reset_row(logic is_null);
    row_t r;
    r.st     = is_null ? PS_RUNNING : PS_FREE;
    r.credit = '0;
    r.prio   = '0;
    r.pend   = '0;
    return r;
  endfunction

  function automatic logic is_active(pstate_t s);
    return (s == PS_RUNNING) || (s == PS_READY);
  endfunction

endpackage

### design/egs_ram.sv
`timescale 1ns / 1ps

module egs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/epoch_goodness_scheduler.sv
`timescale 1ns / 1ps

// Epoch goodness scheduler. The process table lives in one single-port-read RAM, one row per
// process, and a small sequencer walks it one row per cycle. A set-state or set-priority beat
// reads its row and writes it back before giving its result; a beat whose slot is out of range
// or whose func is unknown goes straight to its result. A reschedule beat first writes the
// remaining ticks into the current row; then one pass looks for remaining credit, one pass,
// only when a new epoch starts, refreshes credits and priorities, and one pass picks the process
// of greatest goodness, each pass bounded by the single table read port. Rows not written
// since reset read as their reset contents, so no clearing pass is needed after reset.
// in_tready is high only while the sequencer is idle; a finished result waits in the output
// register without holding up the next input beat.
module epoch_goodness_scheduler
  import egs_pkg::*;
#(
  parameter int NUM_PROCS = EGS_NUM_PROCS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pid[4:0], new_state[6:5], new_priority[14:7], remaining_ticks[23:15]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // chosen_pid[4:0], switched[5], quantum[14:6], zero[15]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(NUM_PROCS);
  localparam int RW = $bits(row_t);
  localparam logic [AW-1:0] LAST = AW'(NUM_PROCS - 1);
  localparam logic [AW:0]   ENDX = (AW + 1)'(NUM_PROCS);

  seq_state_t state_r, state_nxt;

  logic [FUNC_W-1:0]   it_func_r, it_func_nxt;
  logic [PID_W-1:0]    it_pid_r, it_pid_nxt;
  logic [PSTATE_W-1:0] it_state_r, it_state_nxt;
  logic [PRIO_W-1:0]   it_prio_r, it_prio_nxt;
  logic [CREDIT_W-1:0] it_ticks_r, it_ticks_nxt;

  logic [AW-1:0]        cur_r, cur_nxt;
  logic [NUM_PROCS-1:0] valid_r, valid_nxt;
  logic [AW:0]          idx_r, idx_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic [AW-1:0]        rd_addr_r, rd_addr_nxt;
  logic                 rd_ok_r, rd_ok_nxt;
  logic                 found_r, found_nxt;
  logic [GOOD_W-1:0]    best_r, best_nxt;
  logic [AW-1:0]        pick_r, pick_nxt;
  row_t                 pick_row_r, pick_row_nxt;
  row_t                 cur_row_r, cur_row_nxt;

  logic [PID_W-1:0]    res_pid_r, res_pid_nxt;
  logic                res_sw_r, res_sw_nxt;
  logic [CREDIT_W-1:0] res_q_r, res_q_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  row_t          ram_wrow;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;
  logic          rd_issue;

  row_t              ev;
  logic [GOOD_W-1:0] good;
  logic              scan_last;
  logic              in_fire;
  logic              pid_ok;
  logic              out_free;

  egs_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrow),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign pid_ok    = int'(it_pid_r) < NUM_PROCS;
  assign ev        = rd_ok_r ? row_t'(ram_rdata) : reset_row(rd_addr_r == '0);
  assign good      = (ev.credit != '0) ? ({1'b0, ev.credit} + GOOD_W'(ev.prio)) : '0;
  assign scan_last = rd_v_r && (rd_addr_r == LAST);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == FN_RESCHED) begin
            state_nxt = S_CUR_RD;
          end else if ((in_tuser inside {FN_SET_STATE, FN_SET_PRIO}) &&
                       (int'(in_tdata[PID_W-1:0]) < NUM_PROCS)) begin
            state_nxt = S_EDIT_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_EDIT_RD:  state_nxt = S_EDIT_WR;
      S_EDIT_WR:  state_nxt = S_DONE;
      S_CUR_RD:   state_nxt = S_CUR_WR;
      S_CUR_WR:   state_nxt = S_CHECK;
      S_CHECK: begin
        if (scan_last) begin
          if (found_r || (is_active(ev.st) && ev.credit != '0)) begin
            state_nxt = S_PICK;
          end else begin
            state_nxt = S_EPOCH;
          end
        end
      end
      S_EPOCH: begin
        if (scan_last) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (scan_last) begin
          state_nxt = S_FIN_CUR;
        end
      end
      S_FIN_CUR:  state_nxt = S_FIN_PICK;
      S_FIN_PICK: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    it_func_nxt  = it_func_r;
    it_pid_nxt   = it_pid_r;
    it_state_nxt = it_state_r;
    it_prio_nxt  = it_prio_r;
    it_ticks_nxt = it_ticks_r;
    cur_nxt      = cur_r;
    valid_nxt    = valid_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    pick_nxt     = pick_r;
    pick_row_nxt = pick_row_r;
    cur_row_nxt  = cur_row_r;
    res_pid_nxt  = res_pid_r;
    res_sw_nxt   = res_sw_r;
    res_q_nxt    = res_q_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    ram_we    = 1'b0;
    ram_waddr = rd_addr_r;
    ram_wrow  = ev;
    ram_raddr = idx_r[AW-1:0];
    rd_issue  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          it_func_nxt  = in_tuser;
          it_pid_nxt   = in_tdata[4:0];
          it_state_nxt = in_tdata[6:5];
          it_prio_nxt  = in_tdata[14:7];
          it_ticks_nxt = in_tdata[23:15];
          res_pid_nxt  = PID_W'(cur_r);
          res_sw_nxt   = 1'b0;
          res_q_nxt    = '0;
        end
      end
      S_EDIT_RD: begin
        ram_raddr = AW'(it_pid_r);
        rd_issue  = pid_ok;
      end
      S_EDIT_WR: begin
        ram_we = 1'b1;
        if (it_func_r == FN_SET_STATE) begin
          ram_wrow.st = pstate_t'(it_state_r);
          if (pstate_t'(it_state_r) == PS_FREE) begin
            ram_wrow.credit = '0;
          end
        end else begin
          ram_wrow.pend = it_prio_r;
        end
      end
      S_CUR_RD: begin
        ram_raddr = cur_r;
        rd_issue  = 1'b1;
      end
      S_CUR_WR: begin
        ram_we          = 1'b1;
        ram_wrow.credit = it_ticks_r;
        idx_nxt         = (AW + 1)'(1);
        found_nxt       = 1'b0;
      end
      S_CHECK, S_EPOCH, S_PICK: begin
        rd_issue = (idx_r < ENDX);
        if (rd_issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (rd_v_r) begin
          if (state_r == S_CHECK) begin
            if (is_active(ev.st) && ev.credit != '0) begin
              found_nxt = 1'b1;
            end
          end else if (state_r == S_EPOCH) begin
            if (ev.st != PS_FREE) begin
              ram_we          = 1'b1;
              ram_wrow.prio   = ev.pend;
              ram_wrow.credit = CREDIT_W'(ev.credit >> 1) + CREDIT_W'(ev.pend);
            end
          end else begin
            if (rd_addr_r == '0) begin
              pick_row_nxt = ev;
            end
            if (rd_addr_r == cur_r) begin
              cur_row_nxt = ev;
            end
            if (is_active(ev.st) && good > best_r) begin
              best_nxt     = good;
              pick_nxt     = rd_addr_r;
              pick_row_nxt = ev;
            end
          end
        end
        if (scan_last) begin
          idx_nxt  = '0;
          best_nxt = '0;
          pick_nxt = '0;
          if (state_r == S_PICK) begin
            best_nxt = best_r;
            pick_nxt = pick_r;
            if (is_active(ev.st) && good > best_r) begin
              best_nxt = good;
              pick_nxt = rd_addr_r;
            end
          end
        end
      end
      S_FIN_CUR: begin
        ram_waddr   = cur_r;
        ram_wrow    = cur_row_r;
        ram_wrow.st = PS_READY;
        ram_we      = (cur_row_r.st == PS_RUNNING);
      end
      S_FIN_PICK: begin
        ram_waddr   = pick_r;
        ram_wrow    = pick_row_r;
        ram_wrow.st = PS_RUNNING;
        ram_we      = 1'b1;
        cur_nxt     = pick_r;
        res_pid_nxt = PID_W'(pick_r);
        res_sw_nxt  = (pick_r != cur_r);
        res_q_nxt   = pick_row_r.credit;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, res_q_r, res_sw_r, res_pid_r};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase

    if (ram_we) begin
      valid_nxt[ram_waddr] = 1'b1;
    end
    rd_v_nxt    = rd_issue;
    rd_addr_nxt = ram_raddr;
    rd_ok_nxt   = valid_r[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      valid_r     <= '0;
      idx_r       <= '0;
      rd_v_r      <= 1'b0;
      found_r     <= 1'b0;
      best_r      <= '0;
      pick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      valid_r     <= valid_nxt;
      idx_r       <= idx_nxt;
      rd_v_r      <= rd_v_nxt;
      found_r     <= found_nxt;
      best_r      <= best_nxt;
      pick_r      <= pick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_func_r  <= it_func_nxt;
    it_pid_r   <= it_pid_nxt;
    it_state_r <= it_state_nxt;
    it_prio_r  <= it_prio_nxt;
    it_ticks_r <= it_ticks_nxt;
    rd_addr_r  <= rd_addr_nxt;
    rd_ok_r    <= rd_ok_nxt;
    pick_row_r <= pick_row_nxt;
    cur_row_r  <= cur_row_nxt;
    res_pid_r  <= res_pid_nxt;
    res_sw_r   <= res_sw_nxt;
    res_q_r    <= res_q_nxt;
    out_data_r <= out_data_nxt;
  end

  a_pick_null_when_no_goodness: assert property (@(posedge clk) disable iff (!rst_n)
    (best_r == '0) |-> (pick_r == '0))
    else $error("pick moved away from the null process without positive goodness");

  a_epoch_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EPOCH && ram_we && rd_issue) |-> (ram_waddr != ram_raddr))
    else $error("epoch refresh writes the row it is reading");

  a_dispatch_updates_current: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN_PICK) |=> (cur_r == $past(pick_r)))
    else $error("current process not updated at dispatch");

endmodule
